### rtl/cdo_pkg.sv
// ----------------------------------------------------------------------------
// cdo_pkg
// Shared types, constants and calendar functions for the date offset block.
// ----------------------------------------------------------------------------
package cdo_pkg;

	localparam logic [3:0]  MONTHS     = 4'd12;
	localparam logic [3:0]  MONTH_FEB  = 4'd2;
	localparam logic [4:0]  DAY_LAST   = 5'd31;
	localparam logic [8:0]  DAYS_YEAR  = 9'd365;
	localparam logic [8:0]  DAYS_LEAP  = 9'd366;
	localparam logic [13:0] YEAR_MAX   = 14'd9999;

	// Command bundle from the controller to the datapath.
	typedef struct packed {
		logic load;       // clamp the accepted date and form the day count
		logic norm_back;  // step one year back
		logic norm_fwd;   // step one year forward
		logic mon_step;   // step one month forward
		logic out_load;   // capture the finished date in the output register
	} ctrl_cmd_t;

	// Status bundle from the datapath to the controller.
	typedef struct packed {
		logic doy_low;    // day count below one
		logic doy_high;   // day count beyond the current year's length
		logic mon_more;   // day count beyond the current month's length, before December
	} dp_status_t;

	// Length of a month; months outside 1..12 never reach this in use.
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m)
			4'd2:                     len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
			default:                  len = 5'd31;
		endcase
		return len;
	endfunction

	// Days in the months before month m of a common year.
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] d;
		unique case (m)
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

### rtl/cdo_ctrl.sv
// ----------------------------------------------------------------------------
// cdo_ctrl
// Sequencer for the date offset block: accept, year steps, month steps, output.
// ----------------------------------------------------------------------------
module cdo_ctrl
	import cdo_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_NORM  = 4'b0010,
		ST_MONTH = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   m_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_NORM;
				end
			end
			ST_NORM: begin
				priority if (status.doy_low) begin
					cmd.norm_back = 1'b1;
				end else if (status.doy_high) begin
					cmd.norm_fwd = 1'b1;
				end else begin
					state_d = ST_MONTH;
				end
			end
			ST_MONTH: begin
				if (status.mon_more) begin
					cmd.mon_step = 1'b1;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!m_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;

endmodule

### rtl/cdo_dp.sv
// ----------------------------------------------------------------------------
// cdo_dp
// Datapath: date clamp, day count, year and month stepping, output register.
// ----------------------------------------------------------------------------
module cdo_dp
	import cdo_pkg::*;
(
	input  logic               clk,
	input  ctrl_cmd_t          cmd,
	input  logic [3:0]         month_in,
	input  logic [5:0]         day_in,
	input  logic [13:0]        year_in,
	input  logic signed [15:0] offset_days,
	output dp_status_t         status,
	output logic [3:0]         month_out,
	output logic [4:0]         day_out,
	output logic [13:0]        year_out,
	output logic               year_overflow
);

	// Working registers. The year may run a little below zero or above the
	// input range while stepping, so it is kept signed and two bits wider.
	logic signed [15:0] year_q;
	logic signed [16:0] doy_q;
	logic [3:0]         mo_q;

	// Load path.
	logic       in_leap;
	logic [3:0] m_clamp;
	logic [4:0] len_in;
	logic [4:0] d_clamp;
	logic [8:0] doy_base;

	always_comb begin
		in_leap = (year_in[1:0] == 2'd0);
		if (month_in == 4'd0) begin
			m_clamp = 4'd1;
		end else if (month_in > MONTHS) begin
			m_clamp = MONTHS;
		end else begin
			m_clamp = month_in;
		end
		len_in = month_len(m_clamp, in_leap);
		if (day_in == 6'd0) begin
			d_clamp = 5'd1;
		end else if (day_in > {1'b0, len_in}) begin
			d_clamp = len_in;
		end else begin
			d_clamp = day_in[4:0];
		end
		doy_base = days_before(m_clamp) + {8'd0, (in_leap && (m_clamp > MONTH_FEB))}
			+ {4'd0, d_clamp};
	end

	// Stepping path.
	logic       cur_leap;
	logic       prev_leap;
	logic [8:0] diy_cur;
	logic [8:0] diy_prev;
	logic [4:0] dim_cur;

	always_comb begin
		cur_leap  = (year_q[1:0] == 2'd0);
		prev_leap = (year_q[1:0] == 2'd1);
		diy_cur   = cur_leap  ? DAYS_LEAP : DAYS_YEAR;
		diy_prev  = prev_leap ? DAYS_LEAP : DAYS_YEAR;
		dim_cur   = month_len(mo_q, cur_leap);

		status.doy_low  = (doy_q < 17'sd1);
		status.doy_high = (doy_q > $signed({8'd0, diy_cur}));
		status.mon_more = (mo_q < MONTHS) && (doy_q > $signed({12'd0, dim_cur}));
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			year_q <= $signed({2'b00, year_in});
			doy_q  <= $signed({8'd0, doy_base}) + {offset_days[15], offset_days};
			mo_q   <= 4'd1;
		end else if (cmd.norm_back) begin
			year_q <= year_q - 16'sd1;
			doy_q  <= doy_q + $signed({8'd0, diy_prev});
		end else if (cmd.norm_fwd) begin
			year_q <= year_q + 16'sd1;
			doy_q  <= doy_q - $signed({8'd0, diy_cur});
		end else if (cmd.mon_step) begin
			mo_q  <= mo_q + 4'd1;
			doy_q <= doy_q - $signed({12'd0, dim_cur});
		end
	end

	// Output register, with saturation of years outside the supported range.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (year_q < 16'sd0) begin
				month_out     <= 4'd1;
				day_out       <= 5'd1;
				year_out      <= 14'd0;
				year_overflow <= 1'b1;
			end else if (year_q > $signed({2'b00, YEAR_MAX})) begin
				month_out     <= MONTHS;
				day_out       <= DAY_LAST;
				year_out      <= YEAR_MAX;
				year_overflow <= 1'b1;
			end else begin
				month_out     <= mo_q;
				day_out       <= doy_q[4:0];
				year_out      <= year_q[13:0];
				year_overflow <= 1'b0;
			end
		end
	end

endmodule

### rtl/calendar_date_offset_top.sv
// ----------------------------------------------------------------------------
// calendar_date_offset_top
// Moves a calendar date by a signed number of days.
// ----------------------------------------------------------------------------
// The block takes one date and one signed day offset per transaction and
// returns one date per transaction. The month is clamped into 1..12 and the
// day into the length of that month, then the date becomes a day of the year
// and the offset is added. Whole years are then stepped one per clock until
// the count lies inside a year, and months are stepped one per clock until
// the count lies inside a month. Every year divisible by four is a leap year,
// with no century exception, and day 366 of a leap year is December 31. A
// result year below 0 gives January 1 of year 0, a result year above 9999
// gives December 31 of year 9999; both raise the overflow flag in tuser.
// There are about |offset| / 365 whole-year steps, at most about ninety, and
// at most eleven month steps. Items are handled one at a time, but a finished
// result sits in an output register, so the next transaction is taken while
// it waits.
// ----------------------------------------------------------------------------
module calendar_date_offset_top
	import cdo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // month_in[3:0], day_in[9:4], year_in[23:10],
	                               // offset_days[39:24] (signed)
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // month_out[3:0], day_out[8:4], year_out[22:9],
	                               // zero fill [23]
	output logic        m_tuser    // year_overflow[0]
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	logic [3:0]  month_out;
	logic [4:0]  day_out;
	logic [13:0] year_out;

	// The controller owns the handshakes; the datapath never sees them.
	cdo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	cdo_dp u_dp (
		.clk           (clk),
		.cmd           (cmd),
		.month_in      (s_tdata[3:0]),
		.day_in        (s_tdata[9:4]),
		.year_in       (s_tdata[23:10]),
		.offset_days   ($signed(s_tdata[39:24])),
		.status        (status),
		.month_out     (month_out),
		.day_out       (day_out),
		.year_out      (year_out),
		.year_overflow (m_tuser)
	);

	assign m_tdata = {1'b0, year_out, day_out, month_out};

endmodule

### rtl/cdo_chk.sv
// ----------------------------------------------------------------------------
// cdo_chk
// Port-level checks for the date offset block, bound to the top level.
// ----------------------------------------------------------------------------
module cdo_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser
);

	// A result held back by the sink keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// One item at a time: after a transaction is taken the input side is busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item was in progress");

	// Every result is a valid date in the supported year range.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3:0] >= 4'd1) && (m_tdata[3:0] <= 4'd12)
			&& (m_tdata[8:4] >= 5'd1) && (m_tdata[22:9] <= 14'd9999)
			&& (m_tdata[23] == 1'b0))
		else $error("result date out of range");

	// A saturated result is exactly one of the two range-end dates.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
			(m_tdata[22:9] == 14'd0 && m_tdata[3:0] == 4'd1 && m_tdata[8:4] == 5'd1)
			|| (m_tdata[22:9] == 14'd9999 && m_tdata[3:0] == 4'd12
				&& m_tdata[8:4] == 5'd31))
		else $error("saturated result is not a range-end date");

endmodule

bind calendar_date_offset_top cdo_chk u_cdo_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for calendar_date_offset_top.
// ----------------------------------------------------------------------------
// Dates and signed day offsets are sent over the input stream. Each result is
// scored against a typed date or a calendar model held here. A directed table comes
// first and covers clamping, leap days, the last day of a leap year and
// saturation at both ends of the year range. About 1150 random transactions
// follow. Both stream sides pause at random, with some stretches at full rate.
// ----------------------------------------------------------------------------
module tb_top;
	import cdo_pkg::*;

	// One finished date as it leaves the block.
	typedef struct packed {
		logic [3:0]  month;
		logic [4:0]  day;
		logic [13:0] year;
		logic        ovf;
	} date_t;

	// One row of the directed table. When 'typed' is set the expected date is
	// written into the row; otherwise the calendar model supplies it.
	typedef struct packed {
		logic [3:0]  month;
		logic [5:0]  day;
		logic [13:0] year;
		logic [15:0] offset;
		logic        typed;
		date_t       want;
	} plan_row_t;

	localparam bit  TYPED       = 1'b1;
	localparam bit  MODELLED    = 1'b0;
	localparam int  RANDOM_ITEMS = 1150;
	localparam int  IDLE_MAX    = 17;
	localparam int  TAIL_CYCLES = 150;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [39:0] s_tdata  = '0;
	logic        m_tready = 1'b0;
	logic        s_tready;
	logic        m_tvalid;
	logic [23:0] m_tdata;
	logic        m_tuser;

	date_t       pending_dates[$];
	plan_row_t   date_plan[$];
	int          errors      = 0;
	int          n_sent      = 0;
	int          n_checked   = 0;
	int          n_saturated = 0;
	int          sink_hold   = 0;

	calendar_date_offset_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // month_in[3:0], day_in[9:4], year_in[23:10],
		                       // offset_days[39:24]
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // month_out[3:0], day_out[8:4], year_out[22:9], zero fill
		.m_tuser  (m_tuser)    // year_overflow[0]
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Calendar model
	// ------------------------------------------------------------------------

	// Every year divisible by four is a leap year, centuries included. The
	// masking also gives the right answer for the negative years that appear
	// while stepping backwards past year 0.
	function automatic bit leap_year(input int y);
		return (y & 3) == 0;
	endfunction

	function automatic int days_of_month(input int m, input int y);
		if (m == int'(MONTH_FEB))
			return leap_year(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	function automatic int days_of_year(input int y);
		return leap_year(y) ? int'(DAYS_LEAP) : int'(DAYS_YEAR);
	endfunction

	// Works out the date that lies 'off' days from the clamped start date.
	function automatic date_t shift_date(input logic [3:0] mon, input logic [5:0] day,
			input logic [13:0] yr, input logic signed [15:0] off);
		date_t r;
		int    m;
		int    d;
		int    y;
		int    doy;
		m = int'(mon);
		d = int'(day);
		y = int'(yr);
		if (m < 1)
			m = 1;
		if (m > int'(MONTHS))
			m = int'(MONTHS);
		if (d < 1)
			d = 1;
		if (d > days_of_month(m, y))
			d = days_of_month(m, y);
		doy = d;
		for (int i = 1; i < m; i++)
			doy += days_of_month(i, y);
		doy += int'(off);
		// Years are stepped one at a time, as the block does it.
		while (doy < 1) begin
			y--;
			doy += days_of_year(y);
		end
		while (doy > days_of_year(y)) begin
			doy -= days_of_year(y);
			y++;
		end
		r.ovf = 1'b0;
		if (y < 0) begin
			y   = 0;
			m   = 1;
			doy = 1;
			r.ovf = 1'b1;
		end else if (y > int'(YEAR_MAX)) begin
			y   = int'(YEAR_MAX);
			m   = int'(MONTHS);
			doy = int'(DAY_LAST);
			r.ovf = 1'b1;
		end else begin
			// December is never left, so day 366 of a leap year is December 31.
			m = 1;
			while (m < int'(MONTHS) && doy > days_of_month(m, y)) begin
				doy -= days_of_month(m, y);
				m++;
			end
		end
		r.month = 4'(m);
		r.day   = 5'(doy);
		r.year  = 14'(y);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	task automatic add_row(input int m, input int d, input int y, input int off,
			input bit typed, input int em = 0, input int ed = 0, input int ey = 0,
			input int eo = 0);
		plan_row_t row;
		row.month  = 4'(m);
		row.day    = 6'(d);
		row.year   = 14'(y);
		row.offset = 16'(off);
		row.typed  = typed;
		row.want   = {4'(em), 5'(ed), 14'(ey), 1'(eo)};
		date_plan.push_back(row);
	endtask

	// Signed offsets of three sizes: a few days, a few years, the full range.
	function automatic logic [15:0] draw_offset();
		int v;
		case ($urandom_range(0, 3))
			0:       v = int'($urandom_range(0, 80)) - 40;
			1:       v = int'($urandom_range(0, 1600)) - 800;
			default: v = int'($urandom_range(0, 65535));
		endcase
		return 16'(v);
	endfunction

	// Most dates are well formed. The rest lie near the ends of the year range,
	// on month and year boundaries, or use any value that the fields can hold.
	task automatic draw_date(output logic [3:0] mon, output logic [5:0] day,
			output logic [13:0] yr, output logic [15:0] off);
		int v;
		case ($urandom_range(0, 9))
			6: begin
				mon = 4'($urandom_range(1, 12));
				day = 6'($urandom_range(1, 31));
				yr  = $urandom_range(0, 1) ? 14'($urandom_range(0, 60))
				                            : 14'($urandom_range(9940, 9999));
				off = draw_offset();
			end
			7, 8: begin
				mon = 4'($urandom_range(0, 15));
				day = 6'($urandom_range(0, 63));
				yr  = 14'($urandom_range(0, 16383));
				off = 16'($urandom_range(0, 65535));
			end
			9: begin
				mon = $urandom_range(0, 1) ? 4'(MONTHS) : 4'(MONTH_FEB);
				day = 6'($urandom_range(27, 31));
				yr  = 14'($urandom_range(0, 9999));
				v   = int'($urandom_range(0, 6)) - 3;
				off = 16'(v);
			end
			default: begin
				mon = 4'($urandom_range(1, 12));
				day = 6'($urandom_range(1, 31));
				yr  = 14'($urandom_range(0, 9999));
				off = draw_offset();
			end
		endcase
	endtask

	// Offers one date on the input stream and holds it until it is taken.
	// Called just after a rising edge; returns just after the accepting edge.
	task automatic send_date(input logic [3:0] mon, input logic [5:0] day,
			input logic [13:0] yr, input logic [15:0] off, input date_t want);
		int gap;
		// Every third block of a hundred transactions runs at full rate.
		gap = ((n_sent / 100) % 3 == 2) ? 0 : $urandom_range(0, IDLE_MAX);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {off, yr, day, mon};
		do
			@(posedge clk);
		while (!s_tready);
		pending_dates.push_back(want);
		n_sent++;
	endtask

	initial begin : stimulus
		plan_row_t   row;
		logic [3:0]  mon;
		logic [5:0]  day;
		logic [13:0] yr;
		logic [15:0] off;

		// Clamping of month and day, with no offset.
		add_row( 0,  0,  2000,      0, TYPED,  1,  1,  2000, 0);
		add_row(15, 63,  2001,      0, TYPED, 12, 31,  2001, 0);
		add_row( 0, 63,     0,      0, TYPED,  1, 31,     0, 0);
		add_row( 2, 31,  2004,      0, TYPED,  2, 29,  2004, 0);
		add_row( 2, 30,  2003,      0, TYPED,  2, 28,  2003, 0);
		add_row( 4, 31,  1999,      0, TYPED,  4, 30,  1999, 0);
		// Last day of a leap year, reached directly and by stepping into it.
		add_row(12, 31,  2004,      0, TYPED, 12, 31,  2004, 0);
		add_row(12, 30,  2004,      1, TYPED, 12, 31,  2004, 0);
		// Leap day reached backwards, including a century year, and the last day of 9999.
		add_row( 3,  1,  2004,     -1, TYPED,  2, 29,  2004, 0);
		add_row( 3,  1,  2100,     -1, TYPED,  2, 29,  2100, 0);
		add_row( 9, 30,  9999,     92, TYPED, 12, 31,  9999, 0);
		// Saturation below year 0 and above year 9999.
		add_row( 1,  1,     0,     -1, TYPED,  1,  1,     0, 1);
		add_row( 1,  1,     0, -32768, TYPED,  1,  1,     0, 1);
		add_row(12, 31,  9999,      1, TYPED, 12, 31,  9999, 1);
		add_row(12, 31,  9999,  32767, TYPED, 12, 31,  9999, 1);
		// A start year above 9999 only saturates if the result stays there.
		add_row( 6, 15, 16383,      0, TYPED, 12, 31,  9999, 1);
		add_row( 1,  1, 10000,     -1, TYPED, 12, 31,  9999, 0);
		add_row(15,  0, 16383, -32768, MODELLED);
		// Largest steps in each direction and a few ordinary dates.
		add_row( 1,  1,  2000,  32767, MODELLED);
		add_row(12, 31,  2000, -32768, MODELLED);
		add_row( 7,  4,  1776,   1000, MODELLED);
		add_row( 2, 29,  2003,    365, MODELLED);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (date_plan[i]) begin
			row = date_plan[i];
			send_date(row.month, row.day, row.year, row.offset, row.typed ? row.want
			          : shift_date(row.month, row.day, row.year, row.offset));
		end

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			draw_date(mon, day, yr, off);
			send_date(mon, day, yr, off, shift_date(mon, day, yr, off));
		end
		s_tvalid <= 1'b0;

		while (pending_dates.size() != 0)
			@(posedge clk);
		// Any late, unrequested result would be flagged during this tail.
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d dates (%0d from the directed table, the rest random).",
		         n_sent, date_plan.size());
		$display("Checked %0d results, %0d of them with a saturated year.",
		         n_checked, n_saturated);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result side: random back-pressure and scoring
	// ------------------------------------------------------------------------

	// Each result is scored against the oldest expected date at the edge that
	// accepts its transaction. The ready line then drops for a random number
	// of cycles, except in every third block of ninety results.
	always @(posedge clk) begin : result_sink
		date_t got;
		date_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = {m_tdata[3:0], m_tdata[8:4], m_tdata[22:9], m_tuser};
				n_checked++;
				if (got.ovf)
					n_saturated++;
				if (pending_dates.size() == 0) begin
					$error("result with no date outstanding: month %0d day %0d year %0d",
					       got.month, got.day, got.year);
					errors++;
				end else begin
					want = pending_dates.pop_front();
					if (got.month !== want.month) begin
						$error("month_out: expected %0d, got %0d", want.month, got.month);
						errors++;
					end
					if (got.day !== want.day) begin
						$error("day_out: expected %0d, got %0d", want.day, got.day);
						errors++;
					end
					if (got.year !== want.year) begin
						$error("year_out: expected %0d, got %0d", want.year, got.year);
						errors++;
					end
					if (got.ovf !== want.ovf) begin
						$error("year_overflow: expected %0d, got %0d", want.ovf, got.ovf);
						errors++;
					end
				end
				sink_hold = ((n_checked / 90) % 3 == 1) ? 0 : $urandom_range(0, IDLE_MAX);
			end else if (sink_hold > 0) begin
				sink_hold--;
			end
			m_tready <= (sink_hold == 0);
		end
	end

	// Watchdog, several times the slowest correct run.
	initial begin : watchdog
		#20_000_000;
		$display("Timed out with %0d results still outstanding.", pending_dates.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
